@@ rtl/core/lmd_pkg.sv @@
// ----------------------------------------------------------------------------
// lmd_pkg
// Shared constants and types of the majority label dilation block.
// ----------------------------------------------------------------------------
package lmd_pkg;

  localparam int DEF_MAX_DIM_X  = 256;
  localparam int DEF_MAX_DIM_Y  = 256;
  localparam int DEF_MAX_KERNEL = 5;
  localparam int DEF_LABEL_BITS = 16;

  localparam int VOXEL_W     = 16;
  localparam int DEPTH_LIMIT = 4096;
  localparam int POS_Z_W     = 12;
  localparam int DIM_XY_W    = 9;
  localparam int DIM_Z_W     = 13;
  localparam int KERN_W      = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIM_X   = 3'd0,
    CFG_DIM_Y   = 3'd1,
    CFG_DIM_Z   = 3'd2,
    CFG_KERN_X  = 3'd3,
    CFG_KERN_Y  = 3'd4,
    CFG_KERN_Z  = 3'd5,
    CFG_BG      = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_CENTER,
    S_FETCH,
    S_HASH,
    S_PROBE,
    S_EMIT
  } lmd_state_t;

endpackage

@@ rtl/core/lmd_if.sv @@
// ----------------------------------------------------------------------------
// lmd_if
// Valid/ready channels for input voxels and dilated output voxels.
// ----------------------------------------------------------------------------
interface lmd_in_if;
  import lmd_pkg::*;
  logic               valid;
  logic               ready;
  logic [VOXEL_W-1:0] voxel_label;
  logic               drain;

  modport source(output valid, voxel_label, drain, input ready);
  modport sink(input valid, voxel_label, drain, output ready);
endinterface

interface lmd_out_if;
  import lmd_pkg::*;
  logic               valid;
  logic               ready;
  logic [VOXEL_W-1:0] out_label;
  logic               out_last;

  modport source(output valid, out_label, out_last, input ready);
  modport sink(input valid, out_label, out_last, output ready);
endinterface

@@ rtl/core/label_mode_dilation_3d.sv @@
// ----------------------------------------------------------------------------
// label_mode_dilation_3d
// Majority label dilation of a 3D label volume streamed in raster order.
// ----------------------------------------------------------------------------
// Voxels arrive x fastest, then y, then z, and are kept in a ring of
// MAX_KERNEL+1 slices in one single-port-read memory. A non-background voxel
// leaves unchanged; a background voxel becomes the most frequent other label
// of its clipped box, ties going to the label that reached the winning count
// first. The output lags the input by the look-ahead of the box; drain words
// flush it at the end of a volume. Each input word passes through the idle
// and decide steps when no output is due. An output whose voxel is not
// background passes through the decide, center and emit steps; otherwise
// each background box voxel adds a fetch and a hash step, each labeled box
// voxel a fetch, a hash and a probe step, and each hash collision another
// probe step, because the box is read one voxel at a time from the slice
// memory and counted in a small hashed count table. A finished word that
// cannot yet enter the output register holds off the next input word. A
// configuration write to a defined register restarts the volume.
// ----------------------------------------------------------------------------
module label_mode_dilation_3d #(
  parameter int MAX_DIM_X  = lmd_pkg::DEF_MAX_DIM_X,
  parameter int MAX_DIM_Y  = lmd_pkg::DEF_MAX_DIM_Y,
  parameter int MAX_KERNEL = lmd_pkg::DEF_MAX_KERNEL,
  parameter int LABEL_BITS = lmd_pkg::DEF_LABEL_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  lmd_in_if.sink                           in_bus,
  lmd_out_if.source                        out_bus,
  input  logic                             cfg_we,
  input  logic [lmd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lmd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import lmd_pkg::*;

  localparam int XW       = $clog2(MAX_DIM_X);
  localparam int YW       = $clog2(MAX_DIM_Y);
  localparam int ZW       = POS_Z_W;
  localparam int RING     = MAX_KERNEL + 1;
  localparam int SW       = $clog2(RING);
  localparam int AW       = SW + YW + XW;
  localparam int SL_DEPTH = RING << (YW + XW);
  localparam int HOOD_MAX = MAX_KERNEL * MAX_KERNEL * MAX_KERNEL;
  localparam int TW       = $clog2(HOOD_MAX + 1);
  localparam int TSIZE    = 1 << TW;
  localparam int CW       = $clog2(HOOD_MAX + 1);

  typedef logic [LABEL_BITS-1:0] lbl_t;
  typedef struct packed {
    lbl_t          lbl;
    logic [CW-1:0] cnt;
  } tbl_ent_t;

  function automatic logic [12:0] clamp_f(input logic [12:0] v, input logic [12:0] hi);
    logic [12:0] r;
    if (v == 13'd0) r = 13'd1;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  function automatic logic [12:0] lo_f(input logic [12:0] o, input logic [3:0] k);
    logic [12:0] back;
    back = 13'(k >> 1);
    return (o >= back) ? o - back : 13'd0;
  endfunction

  function automatic logic [12:0] hi_f(input logic [12:0] o, input logic [3:0] k,
                                       input logic [12:0] d);
    logic [12:0] ahead;
    logic [12:0] s;
    ahead = 13'(k - 4'd1 - (k >> 1));
    s     = o + ahead;
    return (s > d - 13'd1) ? d - 13'd1 : s;
  endfunction

  // Configuration registers
  logic [DIM_XY_W-1:0] dim_x_r, dim_y_r;
  logic [DIM_Z_W-1:0]  dim_z_r;
  logic [KERN_W-1:0]   kern_x_r, kern_y_r, kern_z_r;
  lbl_t                bg_r;

  // Stream positions
  logic [XW-1:0] in_x_r, out_x_r, bx_r, x0_r, x1_r;
  logic [YW-1:0] in_y_r, out_y_r, by_r, y0_r, y1_r;
  logic [ZW-1:0] in_z_r, out_z_r, bz_r, z1_r;
  logic [SW-1:0] in_slot_r, out_slot_r, bslot_r;
  logic          in_done_r;

  lmd_state_t state_r, state_nxt;

  // Slice ring and count table
  lbl_t          sl_mem [SL_DEPTH];
  lbl_t          sl_q_r;
  tbl_ent_t      tbl_mem [TSIZE];
  tbl_ent_t      tbl_q_r;
  logic [TSIZE-1:0] vld_r;
  logic [TW-1:0] probe_r;
  lbl_t          cur_v_r;
  lbl_t          best_r;
  logic [CW-1:0] best_cnt_r;

  logic                 out_valid_r;
  logic [VOXEL_W-1:0]   out_label_r;
  logic                 out_last_r;

  // Derived extents
  logic [XW:0]   ext_x;
  logic [YW:0]   ext_y;
  logic [12:0]   ext_z;
  logic [3:0]    kx, ky, kz;
  logic [12:0]   bx_lo, bx_hi, by_lo, by_hi, bz_lo, bz_hi;
  logic [SW-1:0] slot0;
  logic          emit_ok;

  always_comb begin
    ext_x = (XW+1)'(clamp_f(13'(dim_x_r), 13'(MAX_DIM_X)));
    ext_y = (YW+1)'(clamp_f(13'(dim_y_r), 13'(MAX_DIM_Y)));
    ext_z = clamp_f(13'(dim_z_r), 13'(DEPTH_LIMIT));
    kx    = 4'(clamp_f(13'(kern_x_r), 13'(MAX_KERNEL)));
    ky    = 4'(clamp_f(13'(kern_y_r), 13'(MAX_KERNEL)));
    kz    = 4'(clamp_f(13'(kern_z_r), 13'(MAX_KERNEL)));
    bx_lo = lo_f(13'(out_x_r), kx);
    bx_hi = hi_f(13'(out_x_r), kx, 13'(ext_x));
    by_lo = lo_f(13'(out_y_r), ky);
    by_hi = hi_f(13'(out_y_r), ky, 13'(ext_y));
    bz_lo = lo_f(13'(out_z_r), kz);
    bz_hi = hi_f(13'(out_z_r), kz, ext_z);
    // Ring slot of the lowest box slice.
    if (13'(out_z_r) < 13'(kz >> 1)) slot0 = '0;
    else if (out_slot_r >= SW'(kz >> 1)) slot0 = out_slot_r - SW'(kz >> 1);
    else slot0 = SW'(out_slot_r + SW'(RING) - SW'(kz >> 1));
    // The whole box must have arrived before the voxel can be finished.
    emit_ok = in_done_r
           || (13'(in_z_r) > bz_hi)
           || (13'(in_z_r) == bz_hi && (13'(in_y_r) > by_hi
           || (13'(in_y_r) == by_hi && 13'(in_x_r) > bx_hi)));
  end

  // Handshake and scan decode
  logic     in_acc, sl_we, load_out, box_last, hit, empty;
  lbl_t     in_lbl;
  logic [CW-1:0] new_cnt;

  assign in_acc   = in_bus.valid && in_bus.ready;
  assign in_lbl   = LABEL_BITS'(in_bus.voxel_label);
  assign sl_we    = in_acc && !in_bus.drain && !in_done_r;
  assign box_last = (bx_r == x1_r) && (by_r == y1_r) && (bz_r == z1_r);
  assign hit      = vld_r[probe_r] && (tbl_q_r.lbl == cur_v_r);
  assign empty    = !vld_r[probe_r];
  assign new_cnt  = hit ? tbl_q_r.cnt + CW'(1) : CW'(1);

  assign out_bus.valid     = out_valid_r;
  assign out_bus.out_label = out_label_r;
  assign out_bus.out_last  = out_last_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_acc) state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = emit_ok ? S_CENTER : S_IDLE;
      S_CENTER: state_nxt = (sl_q_r != bg_r) ? S_EMIT : S_FETCH;
      S_FETCH:  state_nxt = S_HASH;
      S_HASH: begin
        if (sl_q_r != bg_r) state_nxt = S_PROBE;
        else state_nxt = box_last ? S_EMIT : S_FETCH;
      end
      S_PROBE: begin
        if (hit || empty) state_nxt = box_last ? S_EMIT : S_FETCH;
      end
      S_EMIT:   if (load_out) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  logic          sl_re, tb_re, tb_we;
  logic [AW-1:0] sl_raddr;
  logic [TW-1:0] tb_raddr;

  always_comb begin
    in_bus.ready = 1'b0;
    sl_re        = 1'b0;
    sl_raddr     = {bslot_r, by_r, bx_r};
    tb_re        = 1'b0;
    tb_raddr     = probe_r + TW'(1);
    tb_we        = 1'b0;
    load_out     = 1'b0;
    case (state_r)
      S_IDLE:   in_bus.ready = 1'b1;
      S_DECIDE: begin
        sl_re    = emit_ok;
        sl_raddr = {out_slot_r, out_y_r, out_x_r};
      end
      S_FETCH:  sl_re = 1'b1;
      S_HASH: begin
        tb_re    = (sl_q_r != bg_r);
        tb_raddr = TW'(sl_q_r);
      end
      S_PROBE: begin
        tb_we = hit || empty;
        tb_re = !(hit || empty);
      end
      S_EMIT:   load_out = !out_valid_r || out_bus.ready;
      default:  in_bus.ready = 1'b0;
    endcase
  end

  // Memories
  always_ff @(posedge clk) begin
    if (sl_we) sl_mem[{in_slot_r, in_y_r, in_x_r}] <= in_lbl;
    if (sl_re) sl_q_r <= sl_mem[sl_raddr];
  end

  always_ff @(posedge clk) begin
    if (tb_we) tbl_mem[probe_r] <= '{lbl: cur_v_r, cnt: new_cnt};
    if (tb_re) tbl_q_r <= tbl_mem[tb_raddr];
  end

  // Control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dim_x_r     <= DIM_XY_W'(256);
      dim_y_r     <= DIM_XY_W'(256);
      dim_z_r     <= DIM_Z_W'(1);
      kern_x_r    <= KERN_W'(1);
      kern_y_r    <= KERN_W'(1);
      kern_z_r    <= KERN_W'(1);
      bg_r        <= '0;
      in_x_r      <= '0;
      in_y_r      <= '0;
      in_z_r      <= '0;
      in_slot_r   <= '0;
      out_x_r     <= '0;
      out_y_r     <= '0;
      out_z_r     <= '0;
      out_slot_r  <= '0;
      in_done_r   <= 1'b0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      state_r <= state_nxt;

      if (sl_we) begin
        if (13'(in_x_r) + 13'd1 < 13'(ext_x)) begin
          in_x_r <= in_x_r + XW'(1);
        end else begin
          in_x_r <= '0;
          if (13'(in_y_r) + 13'd1 < 13'(ext_y)) begin
            in_y_r <= in_y_r + YW'(1);
          end else begin
            in_y_r <= '0;
            if (13'(in_z_r) + 13'd1 < ext_z) begin
              in_z_r    <= in_z_r + ZW'(1);
              in_slot_r <= (in_slot_r == SW'(RING - 1)) ? '0 : in_slot_r + SW'(1);
            end else begin
              in_z_r    <= '0;
              in_slot_r <= '0;
              in_done_r <= 1'b1;
            end
          end
        end
      end

      if (state_r == S_CENTER) vld_r <= '0;
      if (tb_we) vld_r[probe_r] <= 1'b1;

      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end

      if (load_out) begin
        if (13'(out_x_r) + 13'd1 < 13'(ext_x)) begin
          out_x_r <= out_x_r + XW'(1);
        end else begin
          out_x_r <= '0;
          if (13'(out_y_r) + 13'd1 < 13'(ext_y)) begin
            out_y_r <= out_y_r + YW'(1);
          end else begin
            out_y_r <= '0;
            if (13'(out_z_r) + 13'd1 < ext_z) begin
              out_z_r    <= out_z_r + ZW'(1);
              out_slot_r <= (out_slot_r == SW'(RING - 1)) ? '0 : out_slot_r + SW'(1);
            end else begin
              out_z_r    <= '0;
              out_slot_r <= '0;
              in_done_r  <= 1'b0;
            end
          end
        end
      end

      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_DIM_X:  dim_x_r  <= DIM_XY_W'(cfg_wdata);
          CFG_DIM_Y:  dim_y_r  <= DIM_XY_W'(cfg_wdata);
          CFG_DIM_Z:  dim_z_r  <= DIM_Z_W'(cfg_wdata);
          CFG_KERN_X: kern_x_r <= KERN_W'(cfg_wdata);
          CFG_KERN_Y: kern_y_r <= KERN_W'(cfg_wdata);
          CFG_KERN_Z: kern_z_r <= KERN_W'(cfg_wdata);
          CFG_BG:     bg_r     <= LABEL_BITS'(cfg_wdata);
          default:    bg_r     <= bg_r;
        endcase
        if (cfg_index <= CFG_BG) begin
          in_x_r     <= '0;
          in_y_r     <= '0;
          in_z_r     <= '0;
          in_slot_r  <= '0;
          out_x_r    <= '0;
          out_y_r    <= '0;
          out_z_r    <= '0;
          out_slot_r <= '0;
          in_done_r  <= 1'b0;
        end
      end
    end
  end

  // Box scan and mode tracking; payload only.
  always_ff @(posedge clk) begin
    case (state_r)
      S_CENTER: begin
        best_r     <= (sl_q_r != bg_r) ? sl_q_r : bg_r;
        best_cnt_r <= '0;
        bx_r       <= XW'(bx_lo);
        by_r       <= YW'(by_lo);
        bz_r       <= ZW'(bz_lo);
        bslot_r    <= slot0;
        x0_r       <= XW'(bx_lo);
        x1_r       <= XW'(bx_hi);
        y0_r       <= YW'(by_lo);
        y1_r       <= YW'(by_hi);
        z1_r       <= ZW'(bz_hi);
      end
      S_HASH: begin
        cur_v_r <= sl_q_r;
        probe_r <= TW'(sl_q_r);
      end
      S_PROBE: begin
        if (!(hit || empty)) probe_r <= probe_r + TW'(1);
        if ((hit || empty) && new_cnt > best_cnt_r) begin
          best_r     <= cur_v_r;
          best_cnt_r <= new_cnt;
        end
      end
      S_EMIT: begin
        if (load_out) begin
          out_label_r <= VOXEL_W'(best_r);
          out_last_r  <= (13'(out_x_r) == 13'(ext_x) - 13'd1)
                      && (13'(out_y_r) == 13'(ext_y) - 13'd1)
                      && (13'(out_z_r) == ext_z - 13'd1);
        end
      end
      default: best_r <= best_r;
    endcase
    // Step to the next box voxel once the current one is counted.
    if ((state_r == S_HASH && sl_q_r == bg_r) || (state_r == S_PROBE && (hit || empty))) begin
      if (bx_r != x1_r) begin
        bx_r <= bx_r + XW'(1);
      end else begin
        bx_r <= x0_r;
        if (by_r != y1_r) begin
          by_r <= by_r + YW'(1);
        end else begin
          by_r    <= y0_r;
          bz_r    <= bz_r + ZW'(1);
          bslot_r <= (bslot_r == SW'(RING - 1)) ? '0 : bslot_r + SW'(1);
        end
      end
    end
  end

  a_load_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("output word loaded outside the emit step");

  a_pos_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (13'(in_x_r) < 13'(ext_x)) && (13'(out_x_r) < 13'(ext_x))
    && (13'(in_y_r) < 13'(ext_y)) && (13'(out_y_r) < 13'(ext_y)))
    else $error("stream position outside the volume");

  a_best_not_bg: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_PROBE || state_r == S_FETCH) && best_cnt_r != '0) |-> best_r != bg_r)
    else $error("counted mode equals the background label");

  a_probe_after_hash: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE && $past(state_r) != S_PROBE) |-> $past(state_r == S_HASH))
    else $error("table probe without a fetched voxel");

endmodule

@@ dv/label_mode_dilation_3d_tb.sv @@
// ----------------------------------------------------------------------------
// label_mode_dilation_3d_tb
// Drives label volumes of many shapes, kernel sizes and background labels
// through the block, including clamped register values, restarts in the
// middle of a volume and flush noise. A scoreboard predicts every dilated
// word and checks the output stream field by field under random idling and
// stalls.
// ----------------------------------------------------------------------------
module label_mode_dilation_3d_tb;
  import lmd_pkg::*;

  localparam int RING       = DEF_MAX_KERNEL + 1;
  localparam int STORE_SIZE = RING * DEF_MAX_DIM_Y * DEF_MAX_DIM_X;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE     = 500;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct {
    bit [15:0] label;
    bit        last;
  } voxel_out_t;

  class dilation_scoreboard;
    bit [15:0]  slices [STORE_SIZE];
    bit [8:0]   raw_x, raw_y;
    bit [12:0]  raw_z;
    bit [2:0]   raw_kx, raw_ky, raw_kz;
    bit [15:0]  bg;
    int         ipx, ipy, ipz, opx, opy, opz;
    bit         flushing, finished;
    int         errors;
    voxel_out_t expected_q[$];

    function new();
      raw_x = 9'd256; raw_y = 9'd256; raw_z = 13'd1;
      raw_kx = 3'd1; raw_ky = 3'd1; raw_kz = 3'd1;
      bg = 16'd0;
      errors = 0;
      restart();
    endfunction

    function int clampi(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function int ex(); return clampi(raw_x, 1, DEF_MAX_DIM_X); endfunction
    function int ey(); return clampi(raw_y, 1, DEF_MAX_DIM_Y); endfunction
    function int ez(); return clampi(raw_z, 1, DEPTH_LIMIT); endfunction
    function int kern(int k); return clampi(k, 1, DEF_MAX_KERNEL); endfunction

    function void restart();
      ipx = 0; ipy = 0; ipz = 0;
      opx = 0; opy = 0; opz = 0;
      flushing = 0;
      finished = 0;
    endfunction

    function void write_reg(bit [2:0] idx, bit [15:0] d);
      case (cfg_idx_t'(idx))
        CFG_DIM_X:  raw_x = d[8:0];
        CFG_DIM_Y:  raw_y = d[8:0];
        CFG_DIM_Z:  raw_z = d[12:0];
        CFG_KERN_X: raw_kx = d[2:0];
        CFG_KERN_Y: raw_ky = d[2:0];
        CFG_KERN_Z: raw_kz = d[2:0];
        CFG_BG:     bg = d;
        default:    return;
      endcase
      restart();
    endfunction

    function int slot(int x, int y, int z);
      return ((z % RING) * DEF_MAX_DIM_Y + y) * DEF_MAX_DIM_X + x;
    endfunction

    function longint lin(int x, int y, int z);
      return (longint'(z) * ey() + y) * ex() + x;
    endfunction

    function int reach(int k);
      return k - 1 - k / 2;
    endfunction

    // Most frequent non-background label of the clipped box; a label only
    // takes the lead by passing the current best count, so ties keep the
    // label that got there first in raster order.
    function bit [15:0] majority_at(int ox, int oy, int oz);
      int        cnt [bit [15:0]];
      int        x0, x1, y0, y1, z0, z1, kx, ky, kz, best_n;
      bit [15:0] v, best;
      v = slices[slot(ox, oy, oz)];
      if (v != bg) return v;
      kx = kern(raw_kx); ky = kern(raw_ky); kz = kern(raw_kz);
      x0 = clampi(ox - kx / 2, 0, ex() - 1); x1 = clampi(ox + reach(kx), 0, ex() - 1);
      y0 = clampi(oy - ky / 2, 0, ey() - 1); y1 = clampi(oy + reach(ky), 0, ey() - 1);
      z0 = clampi(oz - kz / 2, 0, ez() - 1); z1 = clampi(oz + reach(kz), 0, ez() - 1);
      best = bg;
      best_n = 0;
      for (int z = z0; z <= z1; z++)
        for (int y = y0; y <= y1; y++)
          for (int x = x0; x <= x1; x++) begin
            v = slices[slot(x, y, z)];
            if (v != bg) begin
              if (!cnt.exists(v)) cnt[v] = 0;
              cnt[v]++;
              if (cnt[v] > best_n) begin
                best_n = cnt[v];
                best = v;
              end
            end
          end
      return best;
    endfunction

    function void note_input(bit [15:0] lab, bit drn);
      int fx, fy, fz;
      voxel_out_t r;
      if (!drn && !flushing) begin
        slices[slot(ipx, ipy, ipz)] = lab;
        finished = 0;
        if (++ipx >= ex()) begin
          ipx = 0;
          if (++ipy >= ey()) begin
            ipy = 0;
            if (++ipz >= ez()) begin
              ipz = 0;
              flushing = 1;
            end
          end
        end
      end
      if (!flushing) begin
        fx = clampi(opx + reach(kern(raw_kx)), 0, ex() - 1);
        fy = clampi(opy + reach(kern(raw_ky)), 0, ey() - 1);
        fz = clampi(opz + reach(kern(raw_kz)), 0, ez() - 1);
        if (lin(ipx, ipy, ipz) <= lin(fx, fy, fz)) return;
      end
      r.label = majority_at(opx, opy, opz);
      r.last = (opx == ex() - 1) && (opy == ey() - 1) && (opz == ez() - 1);
      expected_q.insert(expected_q.size(), r);
      if (++opx >= ex()) begin
        opx = 0;
        if (++opy >= ey()) begin
          opy = 0;
          if (++opz >= ez()) begin
            opz = 0;
            flushing = 0;
            finished = 1;
          end
        end
      end
    endfunction

    function void check_result(bit [15:0] lab, bit last);
      voxel_out_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word, label %h last %0b", $time, lab, last);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (e.label !== lab) begin
        $display("%0t: out_label mismatch, expected %h actual %h", $time, e.label, lab);
        errors++;
      end
      if (e.last !== last) begin
        $display("%0t: out_last mismatch, expected %0b actual %0b", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lmd_in_if  in_ch();
  lmd_out_if out_ch();

  label_mode_dilation_3d dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_ch),
    .out_bus   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  dilation_scoreboard sb = new();
  int src_idle_pct;
  int snk_idle_pct;
  int hold_left;
  int quiet_cycles;
  int random_words;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Scoreboard updates use the values present just before each rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_wdata);
      if (in_ch.valid && in_ch.ready) sb.note_input(in_ch.voxel_label, in_ch.drain);
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.out_label, out_ch.out_last);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("label_mode_dilation_3d_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input logic [15:0] lab, input bit drn);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.voxel_label = lab;
    in_ch.drain = drn;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int v, input int w);
    cfg_we = 1'b1;
    cfg_index = idx;
    // Bits above the register width are random and must be ignored.
    cfg_wdata = CFG_DATA_W'((v & ((1 << w) - 1)) | ($urandom & ~((1 << w) - 1)));
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic run_volume(input int xd, yd, zd, kx, ky, kz, input int bgv,
                            input int share, input int mode, input bit pressure);
    int          n;
    int          r;
    logic [15:0] pool [4];
    logic [15:0] lab;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    case (mode % 4)
      0: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
      1: begin src_idle_pct = 57; snk_idle_pct = 0;  end
      2: begin src_idle_pct = 0;  snk_idle_pct = 57; end
      default: begin src_idle_pct = 24; snk_idle_pct = 24; end
    endcase
    write_reg(CFG_DIM_X, xd, DIM_XY_W);
    write_reg(CFG_DIM_Y, yd, DIM_XY_W);
    write_reg(CFG_DIM_Z, zd, DIM_Z_W);
    write_reg(CFG_KERN_X, kx, KERN_W);
    write_reg(CFG_KERN_Y, ky, KERN_W);
    write_reg(CFG_KERN_Z, kz, KERN_W);
    write_reg(CFG_BG, bgv, CFG_DATA_W);
    if ($urandom_range(3) == 0) write_reg(CFG_UNUSED, $urandom, CFG_DATA_W);
    foreach (pool[j]) pool[j] = 16'($urandom);
    pool[0] = ~sb.bg;
    n = sb.ex() * sb.ey() * sb.ez() * share / 100;
    if (pressure) hold_left = 3000;
    for (int i = 0; i < n; i++) begin
      if (pressure && i == n / 2) begin
        while (sb.expected_q.size() != 0) @(negedge clk);
      end
      if ($urandom_range(19) == 0) send_word(16'($urandom), 1'b1);
      r = $urandom_range(9);
      if (r < 4) lab = sb.bg;
      else if (r < 8) lab = pool[r - 4];
      else lab = 16'($urandom);
      send_word(lab, 1'b0);
    end
    random_words += n;
    // Flush the lag; some voxels sent now must be dropped by the block.
    if (share == 100) begin
      while (!sb.finished) send_word(16'($urandom), ($urandom_range(3) != 0));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.voxel_label = '0;
    in_ch.drain = 1'b0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_left = 0;
    quiet_cycles = 0;
    random_words = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    run_volume(3, 3, 2, 3, 3, 3, 16'h0000, 100, 0, 0);
    run_volume(256, 1, 1, 5, 0, 7, 16'hffff, 100, 1, 0);
    run_volume(1, 256, 1, 2, 5, 1, 16'h00ff, 25, 2, 0);
    run_volume(0, 0, 0, 4, 4, 4, 16'h8000, 100, 3, 0);
    run_volume(511, 1, 1, 1, 1, 1, 16'h0001, 20, 0, 0);
    run_volume(4, 4, 4, 5, 5, 5, 16'h0000, 50, 1, 0);
    run_volume(5, 4, 4, 5, 5, 5, 16'h1234, 100, 0, 1);
    run_volume(1, 1, 8191, 1, 1, 5, 16'h0000, 2, 0, 0);

    for (int k = 0; random_words < 800; k++) begin
      run_volume($urandom_range(9), $urandom_range(7), $urandom_range(5),
                 $urandom_range(7), $urandom_range(7), $urandom_range(7),
                 ($urandom_range(1) == 0) ? 0 : $urandom,
                 ($urandom_range(7) == 0) ? 60 : 100, k, (k == 3));
    end

    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (sb.errors == 0) begin
      $display("label_mode_dilation_3d_tb passed");
    end else begin
      $display("label_mode_dilation_3d_tb failed");
    end
    $finish;
  end

endmodule
